[design/itda_pkg.sv]
// ----------------------------------------------------------------------------
// itda_pkg
// Shared constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itda_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int CHAR_W         = 8;
  localparam int LEN_W          = 4;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

endpackage

`default_nettype wire

[design/itda_if.sv]
// ----------------------------------------------------------------------------
// itda_if
// Valid/ready channels: signed integer in, ASCII character items out.
// ----------------------------------------------------------------------------
`default_nettype none

interface itda_in_if #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if;
  logic                         valid;
  logic                         ready;
  logic [itda_pkg::CHAR_W-1:0]  char_code;
  logic                         is_last;
  logic [itda_pkg::LEN_W-1:0]   text_length;

  modport source (output valid, output char_code, output is_last, output text_length,
                  input ready);
  modport sink   (input valid, input char_code, input is_last, input text_length,
                  output ready);
endinterface

`default_nettype wire

[design/int_to_decimal_ascii_top.sv]
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_top
// Signed integer to decimal ASCII text, one character per output item.
//
// in_ch takes one two's-complement value of VALUE_BITS bits. out_ch returns
// its decimal text most significant first: '-' for negative values, digits
// without leading zeros, a single '0' for zero. is_last marks the final
// character; text_length (total characters, sign included) rides on every one.
//
// A shift-and-add-3 unit builds the BCD digits one input bit per cycle, a
// scan strips one leading zero digit per cycle, then one character leaves
// per cycle while out_ch.ready allows it. Stripped zeros plus digits sent
// equal NDIG. in_ch.ready is high only between numbers, so no new value is
// taken while one is being converted or sent; the last character may
// still wait in the output register while the next is taken.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops
// out_ch.valid. A stall on out_ch holds the current character and pauses
// the emission; nothing is lost.
// ----------------------------------------------------------------------------
`default_nettype none

module int_to_decimal_ascii_top #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  itda_in_if.sink            in_ch,
  itda_out_if.source         out_ch
);
  import itda_pkg::*;

  localparam int NDIG  = ((VALUE_BITS - 1) * 30103) / 100000 + 1;
  localparam int BCD_W = NDIG * 4;
  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int ND_W  = $clog2(NDIG + 1);
  localparam int LW    = $clog2(NDIG + 2);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CONV = 4'b0010,
    ST_SCAN = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t                  state_r, state_nxt;
  logic [VALUE_BITS-1:0]   mag_r, mag_nxt;
  logic [BCD_W-1:0]        bcd_r, bcd_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [ND_W-1:0]         ndig_r, ndig_nxt;
  logic [LW-1:0]           len_r, len_nxt;
  logic                    neg_r, neg_nxt;
  logic                    sign_pend_r, sign_pend_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0]       char_r, char_nxt;
  logic                    last_r, last_nxt;
  logic [LEN_W-1:0]        tlen_r, tlen_nxt;

  logic [BCD_W-1:0]        bcd_adj;
  logic [3:0]              top_dig;
  logic [LW+LEN_W-1:0]     len_ext;
  logic                    can_load;

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
  end

  assign top_dig  = bcd_r[BCD_W-1 -: 4];
  assign len_ext  = {{LEN_W{1'b0}}, len_r};
  assign can_load = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    mag_nxt       = mag_r;
    bcd_nxt       = bcd_r;
    cnt_nxt       = cnt_r;
    ndig_nxt      = ndig_r;
    len_nxt       = len_r;
    neg_nxt       = neg_r;
    sign_pend_nxt = sign_pend_r;
    out_valid_nxt = out_valid_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    tlen_nxt      = tlen_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          neg_nxt   = in_ch.value[VALUE_BITS-1];
          mag_nxt   = in_ch.value[VALUE_BITS-1] ? VALUE_BITS'(-in_ch.value)
                                                : VALUE_BITS'(in_ch.value);
          bcd_nxt   = '0;
          cnt_nxt   = CNT_W'(VALUE_BITS);
          state_nxt = ST_CONV;
        end
      end
      ST_CONV: begin
        {bcd_nxt, mag_nxt} = {bcd_adj, mag_r} << 1;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          ndig_nxt  = ND_W'(NDIG);
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (top_dig == 4'd0 && ndig_r != ND_W'(1)) begin
          bcd_nxt  = bcd_r << 4;
          ndig_nxt = ndig_r - ND_W'(1);
        end else begin
          len_nxt       = LW'(ndig_r) + LW'(neg_r);
          sign_pend_nxt = neg_r;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (can_load) begin
          out_valid_nxt = 1'b1;
          tlen_nxt      = len_ext[LEN_W-1:0];
          if (sign_pend_r) begin
            char_nxt      = ASCII_MINUS;
            last_nxt      = 1'b0;
            sign_pend_nxt = 1'b0;
          end else begin
            char_nxt = ASCII_ZERO + {4'd0, top_dig};
            last_nxt = (ndig_r == ND_W'(1));
            bcd_nxt  = bcd_r << 4;
            ndig_nxt = ndig_r - ND_W'(1);
            if (ndig_r == ND_W'(1)) begin
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      sign_pend_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      sign_pend_r <= sign_pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r  <= mag_nxt;
    bcd_r  <= bcd_nxt;
    cnt_r  <= cnt_nxt;
    ndig_r <= ndig_nxt;
    len_r  <= len_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
    tlen_r <= tlen_nxt;
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.char_code   = char_r;
  assign out_ch.is_last     = last_r;
  assign out_ch.text_length = tlen_r;

endmodule

`default_nettype wire

[test/itda_text_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_text_checker
// Watches the value and character channels of the converter. Every accepted
// value is turned into the decimal text it should produce. Each character
// that leaves is checked field by field against the oldest one still owed.
// ----------------------------------------------------------------------------
module itda_text_checker #(
  parameter int VALUE_BITS = itda_pkg::VALUE_BITS_DEF
) (
  input  wire  clk,
  input  wire  rst_n,
  itda_in_if   in_ch,
  itda_out_if  out_ch,
  output int   mismatch_count,
  output int   chars_pending
);
  import itda_pkg::*;

  localparam int MAX_DIGITS = 24;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              is_last;
    logic [LEN_W-1:0]  text_length;
  } text_char_t;

  text_char_t owed_text[$];
  int         chars_seen = 0;

  initial begin
    mismatch_count = 0;
    chars_pending  = 0;
  end

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) begin
      $display("%0t itda_text_checker: char %0d: %s", $time, chars_seen, msg);
    end
    mismatch_count++;
  endtask

  // Decimal text of one value, sign first, no leading zeros.
  function automatic void queue_decimal_text(input logic [63:0] raw);
    logic [63:0]       mask;
    logic [63:0]       word;
    logic [63:0]       mag;
    logic              neg;
    logic [CHAR_W-1:0] digit_rev [MAX_DIGITS];
    int                ndig;
    int                len;
    int                pos;
    text_char_t        ch;
    mask = (VALUE_BITS >= 64) ? '1 : ((64'd1 << VALUE_BITS) - 64'd1);
    word = raw & mask;
    neg  = word[VALUE_BITS-1];
    mag  = neg ? ((~word + 64'd1) & mask) : word;
    ndig = 0;
    do begin
      digit_rev[ndig] = ASCII_ZERO + CHAR_W'(mag % 64'd10);
      ndig++;
      mag = mag / 64'd10;
    end while (mag != 0 && ndig < MAX_DIGITS);
    len = ndig + (neg ? 1 : 0);
    pos = 0;
    if (neg) begin
      ch.char_code   = ASCII_MINUS;
      ch.is_last     = (len == 1);
      ch.text_length = LEN_W'(len);
      owed_text.push_back(ch);
      pos = 1;
    end
    for (int k = ndig - 1; k >= 0; k--) begin
      ch.char_code   = digit_rev[k];
      ch.is_last     = (pos == len - 1);
      ch.text_length = LEN_W'(len);
      owed_text.push_back(ch);
      pos++;
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_text.size() == 0) begin
          report_mismatch($sformatf("char 0x%02h arrived with none owed", out_ch.char_code));
        end else begin
          want = owed_text.pop_front();
          if (out_ch.char_code !== want.char_code)
            report_mismatch($sformatf("char_code 0x%02h, want 0x%02h",
                                      out_ch.char_code, want.char_code));
          if (out_ch.is_last !== want.is_last)
            report_mismatch($sformatf("is_last %b, want %b", out_ch.is_last, want.is_last));
          if (out_ch.text_length !== want.text_length)
            report_mismatch($sformatf("text_length %0d, want %0d",
                                      out_ch.text_length, want.text_length));
        end
        chars_seen++;
      end
      if (in_ch.valid && in_ch.ready) begin
        queue_decimal_text(64'(in_ch.value));
      end
    end
    chars_pending <= owed_text.size();
  end

endmodule

[test/tb_int_to_decimal_ascii_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_int_to_decimal_ascii_top
// Drives signed values into the converter: corner values first (zero, the
// edges where the text gains a digit, both extremes), then random values of
// every magnitude and sign. Idle patterns on both sides change per phase, and
// once the receiver holds off long enough to back up the input. A side
// checker predicts and compares the text; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_int_to_decimal_ascii_top;
  import itda_pkg::*;

  localparam int VB               = 32;
  localparam int RANDOM_PER_PHASE = 100;
  localparam int HOLD_CYCLES      = 300;
  localparam int DRAIN_CYCLES     = 64;
  localparam int QUIET_LIMIT      = 4000;

  logic clk;
  logic rst_n;
  logic hold_go;
  int   snd_idle_pct;
  int   rcv_idle_pct;
  int   mismatch_count;
  int   chars_pending;

  logic [VB-1:0] corner_values [22] = '{
    32'd0, 32'd1, -32'sd1, 32'd9, -32'sd9, 32'd10, -32'sd10, 32'd99, 32'd100,
    -32'sd100, 32'd999, 32'd1000, 32'd12345, -32'sd67890, 32'd999999999,
    32'd1000000000, -32'sd1000000000, 32'h7FFF_FFFF, 32'h8000_0001,
    32'h8000_0000, 32'd1234567890, -32'sd1234567890
  };

  itda_in_if #(.VALUE_BITS(VB)) in_ch ();
  itda_out_if                   out_ch ();

  int_to_decimal_ascii_top #(.VALUE_BITS(VB)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  itda_text_checker #(.VALUE_BITS(VB)) text_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [VB-1:0] pick_value();
    logic [VB-1:0] v;
    int unsigned   kind;
    int unsigned   tens;
    kind = $urandom_range(0, 9);
    if (kind < 6) begin
      v = $urandom >> $urandom_range(0, 31);
    end else if (kind < 8) begin
      v = 1;
      tens = $urandom_range(0, 9);
      repeat (tens) v = v * 10;
      v = v + $urandom_range(0, 2) - 1;
    end else begin
      v = $urandom;
    end
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  task automatic send_value(input logic [VB-1:0] v);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Receiver: random back-pressure, plus one long hold-off on request.
  initial begin
    int hold_left;
    bit hold_taken;
    hold_left    = 0;
    hold_taken   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        out_ch.ready <= 1'b0;
        hold_left--;
      end else if (hold_go && !hold_taken) begin
        hold_taken = 1;
        hold_left  = HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run after a long stretch with no item moving.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb_int_to_decimal_ascii_top: errors");
        $finish;
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    hold_go      = 1'b0;
    snd_idle_pct = 6;
    rcv_idle_pct = 73;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (corner_values[i]) send_value(corner_values[i]);
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        snd_idle_pct <= 73;
        rcv_idle_pct <= 6;
      end else if (phase == 2) begin
        snd_idle_pct <= 0;
        rcv_idle_pct <= 0;
        hold_go      <= 1'b1;
      end
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_value(pick_value());
    end
    in_ch.valid <= 1'b0;
    @(posedge clk);

    while (chars_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("tb_int_to_decimal_ascii_top: clean");
    end else begin
      $display("tb_int_to_decimal_ascii_top: errors");
    end
    $finish;
  end

endmodule
